// ===== design/spmc_pkg.sv =====
package spmc_pkg;

  localparam int WORD_W = 64;
  localparam int SIG_W = 7;
  localparam int NUM_SIGNALS_DEF = 64;

  localparam logic [2:0] KIND_SET_ACTION = 3'd0;
  localparam logic [2:0] KIND_CHANGE_MASK = 3'd1;
  localparam logic [2:0] KIND_RAISE = 3'd2;
  localparam logic [2:0] KIND_TAKE = 3'd3;
  localparam logic [2:0] KIND_RESTORE = 3'd4;

  localparam logic [1:0] HOW_BLOCK = 2'd0;
  localparam logic [1:0] HOW_UNBLOCK = 2'd1;
  localparam logic [1:0] HOW_SET = 2'd2;
  localparam logic [1:0] HOW_INVALID = 2'd3;

  localparam logic [1:0] DISP_DEFAULT = 2'd0;
  localparam logic [1:0] DISP_IGNORE = 2'd1;
  localparam logic [1:0] DISP_HANDLER = 2'd2;
  localparam logic [1:0] DISP_RESERVED = 2'd3;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_INVAL = 1'b1;

  localparam logic [SIG_W-1:0] SIG_KILL = 7'd9;
  localparam logic [SIG_W-1:0] SIG_STOP = 7'd19;
  localparam logic [SIG_W-1:0] SIG_CHILD = 7'd17;
  localparam logic [SIG_W-1:0] SIG_CONT = 7'd18;
  localparam logic [SIG_W-1:0] SIG_URG = 7'd23;
  localparam logic [SIG_W-1:0] SIG_WINCH = 7'd28;

  localparam logic [WORD_W-1:0] UNBLOCKABLE =
    (WORD_W'(1) << (SIG_KILL - 7'd1)) | (WORD_W'(1) << (SIG_STOP - 7'd1));

  typedef struct packed {
    logic [2:0]        kind;
    logic [SIG_W-1:0]  signal;
    logic [1:0]        how;
    logic              carries_new_value;
    logic [WORD_W-1:0] mask_value;
    logic [1:0]        disposition;
    logic              flag_nodefer;
    logic              flag_resethand;
    logic              flag_restart;
  } spmc_in_t;

  typedef struct packed {
    logic              status;
    logic [WORD_W-1:0] old_blocked;
    logic [SIG_W-1:0]  delivered_signal;
    logic              any_deliverable;
    logic [1:0]        old_disposition;
    logic [WORD_W-1:0] old_action_mask;
    logic              old_nodefer;
    logic              old_resethand;
    logic              old_restart;
    logic              wants_restart;
  } spmc_out_t;

  typedef struct packed {
    logic [WORD_W-1:0] mask;
    logic              restart;
    logic              resethand;
    logic              nodefer;
    logic [1:0]        disp;
  } spmc_act_t;

  typedef struct packed {
    logic load;
    logic read;
    logic exec;
    logic publish;
  } spmc_cmd_t;

  typedef struct packed {
    logic take;
    logic ready_any;
    logic skip;
  } spmc_stat_t;

endpackage

// ===== design/spmc_ctrl.sv =====
module spmc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  input  spmc_pkg::spmc_stat_t stat,
  output spmc_pkg::spmc_cmd_t  cmd
);
  import spmc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_EXEC = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   rsp_valid_next;

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    cmd.load = (state == ST_IDLE) && req_valid;
    cmd.read = (state == ST_READ);
    cmd.exec = (state == ST_EXEC);
    cmd.publish = (state == ST_DONE) && (!rsp_valid || rsp_ready);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_READ;
      end
      ST_READ: begin
        if (stat.take && !stat.ready_any) state_next = ST_DONE;
        else state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat.take && stat.skip) state_next = ST_READ;
        else state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_valid || rsp_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.publish) rsp_valid_next = 1'b1;
    else if (rsp_ready) rsp_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state == ST_READ)
    else $error("accepted beat did not start a table read");

  a_publish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> rsp_valid)
    else $error("published result not presented");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && rsp_valid && !rsp_ready |=> state == ST_DONE)
    else $error("result finished while output register was still occupied");

endmodule

// ===== design/spmc_dp.sv =====
module spmc_dp #(
  parameter int NUM_SIGNALS = spmc_pkg::NUM_SIGNALS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  spmc_pkg::spmc_in_t   req,
  input  spmc_pkg::spmc_cmd_t  cmd,
  output spmc_pkg::spmc_stat_t stat,
  output spmc_pkg::spmc_out_t  rsp
);
  import spmc_pkg::*;

  localparam int IDX_W = $clog2(NUM_SIGNALS);
  localparam logic [SIG_W-1:0] SIG_MAX = SIG_W'(NUM_SIGNALS);
  localparam logic [WORD_W-1:0] VALID_MASK = {WORD_W{1'b1}} >> (WORD_W - NUM_SIGNALS);
  localparam logic [WORD_W-1:0] BLOCK_KEEP = VALID_MASK & ~UNBLOCKABLE;

  spmc_in_t          item;
  spmc_out_t         res;
  spmc_out_t         res_init;
  spmc_out_t         rsp_pub;
  spmc_out_t         rsp_r;
  logic [WORD_W-1:0] pending;
  logic [WORD_W-1:0] blocked;

  spmc_act_t         act_mem [NUM_SIGNALS];
  logic [NUM_SIGNALS-1:0] act_valid;
  spmc_act_t         rd_act;
  logic              rd_valid;
  logic [IDX_W-1:0]  scan_idx;

  logic [WORD_W-1:0] ready_bits;
  logic [IDX_W-1:0]  low_idx;
  logic [IDX_W-1:0]  rd_addr;
  logic [SIG_W-1:0]  sig_m1;
  logic [IDX_W-1:0]  item_idx;
  logic [WORD_W-1:0] item_bit;
  logic              sig_ok;
  logic              set_ok;
  spmc_act_t         cur_act;
  logic [SIG_W-1:0]  scan_sig;
  logic [WORD_W-1:0] scan_bit;
  logic              def_ign;
  logic              skip;
  logic [WORD_W-1:0] deliver_blocked;
  spmc_act_t         new_act;
  logic              mem_we;
  logic [IDX_W-1:0]  wr_addr;
  spmc_act_t         wr_act;

  assign ready_bits = pending & ~blocked & VALID_MASK;

  always_comb begin
    low_idx = '0;
    for (int i = NUM_SIGNALS - 1; i >= 0; i--) begin
      if (ready_bits[i]) low_idx = IDX_W'(i);
    end
  end

  assign sig_m1 = item.signal - SIG_W'(1);
  assign item_idx = sig_m1[IDX_W-1:0];
  assign item_bit = WORD_W'(1) << sig_m1[5:0];
  assign sig_ok = (item.signal != '0) && (item.signal <= SIG_MAX);
  assign set_ok = sig_ok && (item.signal != SIG_KILL) && (item.signal != SIG_STOP);

  assign cur_act = rd_valid ? rd_act : '0;
  assign scan_sig = SIG_W'(scan_idx) + SIG_W'(1);
  assign scan_bit = WORD_W'(1) << scan_idx;
  assign def_ign = (scan_sig == SIG_CHILD) || (scan_sig == SIG_CONT) ||
                   (scan_sig == SIG_URG) || (scan_sig == SIG_WINCH);
  assign skip = (cur_act.disp == DISP_IGNORE) || ((cur_act.disp == DISP_DEFAULT) && def_ign);
  assign deliver_blocked = blocked | cur_act.mask | (cur_act.nodefer ? '0 : scan_bit);

  always_comb begin
    new_act.mask = item.mask_value & VALID_MASK;
    new_act.restart = item.flag_restart;
    new_act.resethand = item.flag_resethand;
    new_act.nodefer = item.flag_nodefer;
    new_act.disp = (item.disposition == DISP_RESERVED) ? DISP_HANDLER : item.disposition;
  end

  assign stat.take = (item.kind == KIND_TAKE);
  assign stat.ready_any = |ready_bits;
  assign stat.skip = skip;

  assign rd_addr = stat.take ? low_idx : item_idx;
  assign mem_we = cmd.exec &&
                  (((item.kind == KIND_SET_ACTION) && set_ok && item.carries_new_value) ||
                   ((item.kind == KIND_TAKE) && !skip && cur_act.resethand));
  assign wr_addr = stat.take ? scan_idx : item_idx;

  always_comb begin
    if (stat.take) begin
      wr_act = cur_act;
      wr_act.disp = DISP_DEFAULT;
    end else begin
      wr_act = new_act;
    end
  end

  always_comb begin
    res_init = '0;
    res_init.old_blocked = blocked;
  end

  always_comb begin
    rsp_pub = res;
    rsp_pub.any_deliverable = |(pending & ~blocked);
  end

  always_ff @(posedge clk) begin
    if (mem_we) act_mem[wr_addr] <= wr_act;
    if (cmd.read) begin
      rd_act <= act_mem[rd_addr];
      rd_valid <= act_valid[rd_addr];
      scan_idx <= low_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid <= '0;
    end else if (mem_we) begin
      act_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      blocked <= '0;
    end else if (cmd.exec) begin
      case (item.kind)
        KIND_CHANGE_MASK: begin
          if (item.carries_new_value) begin
            case (item.how)
              HOW_BLOCK: blocked <= (blocked | item.mask_value) & BLOCK_KEEP;
              HOW_UNBLOCK: blocked <= blocked & ~item.mask_value & BLOCK_KEEP;
              HOW_SET: blocked <= item.mask_value & BLOCK_KEEP;
              default: ;
            endcase
          end
        end
        KIND_RAISE: begin
          if (sig_ok) pending <= pending | item_bit;
        end
        KIND_TAKE: begin
          pending <= pending & ~scan_bit;
          if (!skip) blocked <= deliver_blocked & BLOCK_KEEP;
        end
        KIND_RESTORE: blocked <= item.mask_value & BLOCK_KEEP;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= req;
      res <= res_init;
    end
    if (cmd.exec) begin
      case (item.kind)
        KIND_SET_ACTION: begin
          if (!set_ok) begin
            res.status <= STATUS_INVAL;
          end else begin
            res.old_disposition <= cur_act.disp;
            res.old_action_mask <= cur_act.mask;
            res.old_nodefer <= cur_act.nodefer;
            res.old_resethand <= cur_act.resethand;
            res.old_restart <= cur_act.restart;
          end
        end
        KIND_CHANGE_MASK: begin
          if (item.carries_new_value && (item.how != HOW_BLOCK) &&
              (item.how != HOW_UNBLOCK) && (item.how != HOW_SET)) begin
            res.status <= STATUS_INVAL;
          end
        end
        KIND_TAKE: begin
          if (!skip) begin
            res.delivered_signal <= scan_sig;
            res.wants_restart <= cur_act.restart;
            res.old_disposition <= cur_act.disp;
            res.old_action_mask <= cur_act.mask;
            res.old_nodefer <= cur_act.nodefer;
            res.old_resethand <= cur_act.resethand;
            res.old_restart <= cur_act.restart;
          end
        end
        KIND_RAISE, KIND_RESTORE: ;
        default: res.status <= STATUS_INVAL;
      endcase
    end
    if (cmd.publish) begin
      rsp_r <= rsp_pub;
    end
  end

  assign rsp = rsp_r;

  a_kill_stop_open: assert property (@(posedge clk) disable iff (rst)
    (blocked & UNBLOCKABLE) == '0)
    else $error("kill or stop became blocked");

  a_no_high_bits: assert property (@(posedge clk) disable iff (rst)
    ((pending | blocked) & ~VALID_MASK) == '0)
    else $error("bit above the signal range stored");

  a_delivery_reported: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && stat.take && !stat.skip |=> res.delivered_signal != '0)
    else $error("delivery step left no signal number in the result");

endmodule

// ===== design/signal_pending_mask_controller_core.sv =====
// Channel  Direction  Handshake               Payload
// req      in         req_valid / req_ready   spmc_in_t
// rsp      out        rsp_valid / rsp_ready   spmc_out_t
//
// An item passes from acceptance through a table read and an execute step to its
// result beat; a take and deliver repeats both for every ignored signal the scan
// drops, and skips execute if nothing is deliverable. Each scan step reads the table.
// Reset clears pending, blocked and the action table valid bits.
// A new request is accepted while the previous result waits in the output register.
module signal_pending_mask_controller_core #(
  parameter int NUM_SIGNALS = spmc_pkg::NUM_SIGNALS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  spmc_pkg::spmc_in_t  req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output spmc_pkg::spmc_out_t rsp
);
  import spmc_pkg::*;

  spmc_cmd_t  cmd;
  spmc_stat_t stat;

  spmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spmc_dp #(
    .NUM_SIGNALS (NUM_SIGNALS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule
